// ===== rtl/core/tgr_pkg.sv =====
package tgr_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ThreshW = 15;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 5;

  // class and action codes
  typedef enum logic [2:0] {
    CLS_RIGHT   = 3'd0,
    CLS_RETURN  = 3'd1,
    CLS_LEFT    = 3'd2,
    CLS_UP      = 3'd3,
    CLS_DOWN    = 3'd4,
    CLS_FORWARD = 3'd5,
    CLS_SHAKE   = 3'd6,
    CLS_UNKNOWN = 3'd7
  } class_e;

  // register indexes, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_FLIP_X    = 3'd0,
    REG_FLIP_Y    = 3'd1,
    REG_SWAP_XY   = 3'd2,
    REG_TURN_TH   = 3'd3,
    REG_TILT_TH   = 3'd4,
    REG_SHAKE_TH  = 3'd5,
    REG_SPARE_6   = 3'd6,
    REG_SPARE_7   = 3'd7
  } reg_idx_e;

  localparam logic [ThreshW-1:0] TurnThReset  = 15'd4000;
  localparam logic [ThreshW-1:0] TiltThReset  = 15'd5000;
  localparam logic [ThreshW-1:0] ShakeThReset = 15'd1000;

  typedef struct packed {
    logic               flip_x;
    logic               flip_y;
    logic               swap_xy;
    logic [ThreshW-1:0] turn_th;
    logic [ThreshW-1:0] tilt_th;
    logic [ThreshW-1:0] shake_th;
  } cfg_t;

  // remapped sample between the input stage and the decision stage
  typedef struct packed {
    logic                      valid;
    logic signed [SampleW-1:0] x;
    logic signed [SampleW-1:0] y;
    logic                      clear_latch;
  } stage_t;

endpackage

// ===== rtl/core/tgr_sample_if.sv =====
interface tgr_sample_if;
  import tgr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] accel_x;
  logic signed [SampleW-1:0] accel_y;
  logic                      clear_latch;

  modport source (output valid, accel_x, accel_y, clear_latch, input ready);
  modport sink (input valid, accel_x, accel_y, clear_latch, output ready);
endinterface

// ===== rtl/core/tgr_result_if.sv =====
interface tgr_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] sample_class;
  logic       action_valid;
  logic [2:0] latched_action;

  modport source (output valid, sample_class, action_valid, latched_action, input ready);
  modport sink (input valid, sample_class, action_valid, latched_action, output ready);
endinterface

// ===== rtl/core/tgr_cfg.sv =====
module tgr_cfg
  import tgr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_FLIP_X:   cfg_d.flip_x   = pwdata[0];
        REG_FLIP_Y:   cfg_d.flip_y   = pwdata[0];
        REG_SWAP_XY:  cfg_d.swap_xy  = pwdata[0];
        REG_TURN_TH:  cfg_d.turn_th  = pwdata[ThreshW-1:0];
        REG_TILT_TH:  cfg_d.tilt_th  = pwdata[ThreshW-1:0];
        REG_SHAKE_TH: cfg_d.shake_th = pwdata[ThreshW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FLIP_X:   prdata = {{(ApbDataW-1){1'b0}}, cfg_q.flip_x};
      REG_FLIP_Y:   prdata = {{(ApbDataW-1){1'b0}}, cfg_q.flip_y};
      REG_SWAP_XY:  prdata = {{(ApbDataW-1){1'b0}}, cfg_q.swap_xy};
      REG_TURN_TH:  prdata = {{(ApbDataW-ThreshW){1'b0}}, cfg_q.turn_th};
      REG_TILT_TH:  prdata = {{(ApbDataW-ThreshW){1'b0}}, cfg_q.tilt_th};
      REG_SHAKE_TH: prdata = {{(ApbDataW-ThreshW){1'b0}}, cfg_q.shake_th};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flip_x   <= 1'b0;
      cfg_q.flip_y   <= 1'b0;
      cfg_q.swap_xy  <= 1'b0;
      cfg_q.turn_th  <= TurnThReset;
      cfg_q.tilt_th  <= TiltThReset;
      cfg_q.shake_th <= ShakeThReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/tgr_remap.sv =====
module tgr_remap
  import tgr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  tgr_sample_if.sink   sample_i,
  input  cfg_t         cfg_i,
  input  logic         take_i,
  output stage_t       stage_o
);

  logic                      valid_q, valid_d;
  logic signed [SampleW-1:0] x_q, y_q;
  logic                      clear_q;
  logic signed [SampleW-1:0] x_neg, y_neg;
  logic                      accept;

  assign sample_i.ready = !valid_q || take_i;
  assign accept         = sample_i.valid && sample_i.ready;

  // two's-complement negate, the most negative value wraps to itself
  assign x_neg = cfg_i.flip_x ? (~sample_i.accel_x) + 16'sd1 : sample_i.accel_x;
  assign y_neg = cfg_i.flip_y ? (~sample_i.accel_y) + 16'sd1 : sample_i.accel_y;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q     <= cfg_i.swap_xy ? y_neg : x_neg;
      y_q     <= cfg_i.swap_xy ? x_neg : y_neg;
      clear_q <= sample_i.clear_latch;
    end
  end

  assign stage_o.valid       = valid_q;
  assign stage_o.x           = x_q;
  assign stage_o.y           = y_q;
  assign stage_o.clear_latch = clear_q;

endmodule

// ===== rtl/core/tgr_decide.sv =====
module tgr_decide
  import tgr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  stage_t       stage_i,
  input  cfg_t         cfg_i,
  output logic         take_o,
  tgr_result_if.source result_o
);

  logic signed [SampleW:0] x_ext, y_ext;
  logic signed [SampleW:0] turn_p, turn_n, tilt_p, tilt_n, shake_p, shake_n;
  class_e cls;
  class_e hist1_q, hist1_d, hist2_q, hist2_d;
  logic   flag_q, flag_d, flag_eff;
  class_e code_q, code_d;
  logic   run;
  logic   out_valid_q, out_valid_d;
  class_e out_class_q;
  logic   adv;

  assign take_o = !out_valid_q || result_o.ready;
  assign adv    = stage_i.valid && take_o;

  assign x_ext   = {stage_i.x[SampleW-1], stage_i.x};
  assign y_ext   = {stage_i.y[SampleW-1], stage_i.y};
  assign turn_p  = signed'({2'b00, cfg_i.turn_th});
  assign tilt_p  = signed'({2'b00, cfg_i.tilt_th});
  assign shake_p = signed'({2'b00, cfg_i.shake_th});
  assign turn_n  = -turn_p;
  assign tilt_n  = -tilt_p;
  assign shake_n = -shake_p;

  // y axis wins over x, strict compares
  always_comb begin
    priority if (y_ext > turn_p) begin
      cls = CLS_LEFT;
    end else if (y_ext < turn_n) begin
      cls = CLS_RIGHT;
    end else if (y_ext > shake_p || y_ext < shake_n) begin
      cls = CLS_SHAKE;
    end else if (x_ext > tilt_p) begin
      cls = CLS_UP;
    end else if (x_ext < tilt_n) begin
      cls = CLS_DOWN;
    end else if (x_ext > shake_p || x_ext < shake_n) begin
      cls = CLS_SHAKE;
    end else begin
      cls = CLS_UNKNOWN;
    end
  end

  assign flag_eff = flag_q && !stage_i.clear_latch;
  assign run      = (cls == hist1_q) && (hist1_q == hist2_q) &&
                    (cls == CLS_UP || cls == CLS_DOWN);

  always_comb begin
    hist1_d     = hist1_q;
    hist2_d     = hist2_q;
    flag_d      = flag_q;
    code_d      = code_q;
    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = stage_i.valid;
    end
    if (adv) begin
      hist1_d = cls;
      hist2_d = hist1_q;
      flag_d  = flag_eff;
      if (!flag_eff) begin
        if (cls != CLS_UNKNOWN) begin
          flag_d = 1'b1;
          code_d = cls;
        end
        if (run) begin
          flag_d  = 1'b1;
          code_d  = (cls == CLS_UP) ? CLS_FORWARD : CLS_RETURN;
          hist2_d = CLS_UNKNOWN;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist1_q     <= CLS_UNKNOWN;
      hist2_q     <= CLS_UNKNOWN;
      flag_q      <= 1'b0;
      code_q      <= CLS_UNKNOWN;
      out_valid_q <= 1'b0;
    end else begin
      hist1_q     <= hist1_d;
      hist2_q     <= hist2_d;
      flag_q      <= flag_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_class_q <= cls;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.sample_class   = out_class_q;
  assign result_o.action_valid   = flag_q;
  assign result_o.latched_action = code_q;

  a_run_upgrades: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !flag_eff && run |=> flag_q && (code_q == CLS_FORWARD || code_q == CLS_RETURN))
    else $error("run of three did not upgrade the latch");

  a_latch_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && flag_eff |=> flag_q && $stable(code_q))
    else $error("latched action changed while held");

  a_known_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !flag_eff && cls != CLS_UNKNOWN |=> flag_q)
    else $error("known class did not set the latch");

  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !flag_eff && run |=> hist2_q == CLS_UNKNOWN)
    else $error("history not cleared after run");

endmodule

// ===== rtl/core/tilt_gesture_recognizer.sv =====
// tilt gesture recognizer
//
// sample_i takes one accelerometer request per cycle (accel_x, accel_y and a
// clear_latch bit from the consumer). result_o returns exactly one request per
// sample: the sample's class, the latch flag and the latched action code.
// the APB port holds the orientation remap (flip x, flip y, swap) and the
// turn, tilt and shake thresholds; write it only while the block is empty.
//
// a sample passes the input stage with the remap, then the classify/history/latch
// stage feeding the result register.
// throughput: one sample per cycle; the history and latch update for a sample
// completes in the same cycle it moves into the result register, so the
// next sample sees it immediately.
//
// reset: registers return to their defaults, history reads unknown, the latch
// is empty with code unknown, and both stages are empty.
// when result_o.ready is low the result and input stages hold; sample_i keeps
// accepting until both stages are full, then ready drops until a result moves.
module tilt_gesture_recognizer
  import tgr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  // streams
  tgr_sample_if.sink          sample_i,
  tgr_result_if.source        result_o
);

  cfg_t   cfg;
  stage_t stage;
  logic   take;

  // register file
  tgr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input stage: negate and swap, then register
  tgr_remap u_remap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .cfg_i    (cfg),
    .take_i   (take),
    .stage_o  (stage)
  );

  // classify, update history and latch, result register
  tgr_decide u_decide (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (stage),
    .cfg_i    (cfg),
    .take_o   (take),
    .result_o (result_o)
  );

endmodule
